[src/istf_pkg.sv]
// ----------------------------------------------------------------------------
// istf_pkg
// Shared types and constants for the identifier slot table.
// ----------------------------------------------------------------------------
package istf_pkg;

  localparam int unsigned ActW = 2;
  localparam int unsigned IdW  = 32;
  localparam int unsigned OutIdxW = 3;

  localparam logic [ActW-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ActW-1:0] ACT_TOGGLE = 2'd1;
  localparam logic [ActW-1:0] ACT_MARK   = 2'd2;

  localparam logic [IdW-1:0] EMPTY_ID = 32'hFFFF_FFFF;
  localparam logic [IdW-1:0] AUTO_A_ID = 32'h0000_0001;

  typedef struct packed {
    logic load;
    logic exec;
  } istf_cmd_t;

endpackage

[src/istf_ctrl.sv]
// ----------------------------------------------------------------------------
// istf_ctrl
// Sequencer: takes an item, runs one table update, holds the result until
// it is taken.
// ----------------------------------------------------------------------------
module istf_ctrl
  import istf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output istf_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign cmd_o.load = in_valid_i && in_ready_o;
  assign cmd_o.exec = (state_q == S_EXEC);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.load) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.exec || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[src/istf_dp.sv]
// ----------------------------------------------------------------------------
// istf_dp
// Table storage, parallel match/free search and result register.
// ----------------------------------------------------------------------------
module istf_dp
  import istf_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  istf_cmd_t           cmd_i,
  input  logic [ActW-1:0]     action_i,
  input  logic [IdW-1:0]      slot_id_i,
  input  logic                object_present_i,
  output logic                flag_value_o,
  output logic                matched_o,
  output logic                dropped_o,
  output logic [OutIdxW-1:0]  entry_index_o
);

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [ActW-1:0] action_q;
  logic [IdW-1:0]  id_q;
  logic            present_q;

  logic [IdW-1:0]        ids_q [SLOT_COUNT];
  logic [IdW-1:0]        ids_d [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] fa_q, fa_d, fb_q, fb_d;

  logic [SLOT_COUNT-1:0] hit_vec, free_vec;
  logic                  hit_any, free_any;
  logic [IdxW-1:0]       hit_idx, free_idx;

  logic              flag_value_q, flag_value_d;
  logic              matched_q, matched_d;
  logic              dropped_q, dropped_d;
  logic [IdxW-1:0]   index_q, index_d;
  logic [IdxW+OutIdxW-1:0] index_ext;

  // input register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q  <= action_i;
      id_q      <= slot_id_i;
      present_q <= object_present_i;
    end
  end

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit_vec[i]  = (ids_q[i] == id_q);
      free_vec[i] = (ids_q[i] == EMPTY_ID);
    end
  end

  // first set bit wins
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IdxW'(i);
      end
      if (free_vec[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  assign hit_any  = |hit_vec;
  assign free_any = |free_vec;

  always_comb begin
    ids_d        = ids_q;
    fa_d         = fa_q;
    fb_d         = fb_q;
    flag_value_d = 1'b0;
    matched_d    = 1'b0;
    dropped_d    = 1'b0;
    index_d      = '0;
    unique case (action_q)
      ACT_CLEAR: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          ids_d[i] = EMPTY_ID;
        end
        fa_d = '0;
        fb_d = '0;
      end
      ACT_TOGGLE: begin
        if (present_q && hit_any) begin
          fa_d[hit_idx] = ~fa_q[hit_idx];
          flag_value_d  = ~fa_q[hit_idx];
          matched_d     = 1'b1;
          index_d       = hit_idx;
        end
      end
      ACT_MARK: begin
        if (hit_any) begin
          fb_d[hit_idx] = 1'b1;
          matched_d     = 1'b1;
          index_d       = hit_idx;
        end else if (free_any) begin
          ids_d[free_idx] = id_q;
          fa_d[free_idx]  = (id_q == AUTO_A_ID);
          fb_d[free_idx]  = 1'b1;
          index_d         = free_idx;
        end else begin
          dropped_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        ids_q[i] <= EMPTY_ID;
      end
      fa_q <= '0;
      fb_q <= '0;
    end else if (cmd_i.exec) begin
      ids_q <= ids_d;
      fa_q  <= fa_d;
      fb_q  <= fb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      flag_value_q <= flag_value_d;
      matched_q    <= matched_d;
      dropped_q    <= dropped_d;
      index_q      <= index_d;
    end
  end

  assign index_ext     = {{OutIdxW{1'b0}}, index_q};
  assign flag_value_o  = flag_value_q;
  assign matched_o     = matched_q;
  assign dropped_o     = dropped_q;
  assign entry_index_o = index_ext[OutIdxW-1:0];

endmodule

[src/id_slot_table_with_flags_unit.sv]
// Flow: a transfer enters the update state; one search-and-update over all
// entries runs in parallel, writing the result and setting result valid. No
// new item is taken during it, and a result not taken holds off input.
// Reset: asynchronous, active low; every entry empty, both flags cleared,
// no result pending.
// ----------------------------------------------------------------------------
// id_slot_table_with_flags_unit
// Associative identifier table with per-entry flags: clear, toggle, mark.
// ----------------------------------------------------------------------------
module id_slot_table_with_flags_unit
  import istf_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] slot_id_i,
  input  logic               object_present_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               flag_value_o,
  output logic               matched_o,
  output logic               dropped_o,
  output logic [2:0]         entry_index_o
);

  istf_cmd_t cmd;

  istf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  istf_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .action_i         (action_i),
    .slot_id_i        (slot_id_i),
    .object_present_i (object_present_i),
    .flag_value_o     (flag_value_o),
    .matched_o        (matched_o),
    .dropped_o        (dropped_o),
    .entry_index_o    (entry_index_o)
  );

  a_exec_follows_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> cmd.exec)
    else $error("update cycle did not follow transfer");

  a_exec_into_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> !out_valid_o)
    else $error("result register overwritten");

  a_drop_excl_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(dropped_o && matched_o))
    else $error("dropped and matched together");

  a_flag_needs_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && flag_value_o) |-> matched_o)
    else $error("flag value without match");

endmodule

[tb/tb_id_slot_table_with_flags_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_id_slot_table_with_flags_unit
// Self-checking bench for the identifier slot table. A short directed run is
// followed by random clear, toggle, mark and spare-action transfers with random
// gaps and stalls. Each result is checked against an in-bench copy of the table.
// ----------------------------------------------------------------------------
module tb_id_slot_table_with_flags_unit;
  import istf_pkg::*;

  localparam int Slots = 8;
  localparam int RandOps = 1400;
  localparam logic [ActW-1:0] ACT_SPARE = 2'd3;

  typedef struct {
    logic [ActW-1:0] action;
    logic [IdW-1:0]  id;
    logic            present;
  } table_op_t;

  typedef struct {
    logic               flag;
    logic               matched;
    logic               dropped;
    logic [OutIdxW-1:0] idx;
  } table_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         action_i = ACT_CLEAR;
  logic signed [31:0] slot_id_i = '0;
  logic               object_present_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               flag_value_o;
  logic               matched_o;
  logic               dropped_o;
  logic [2:0]         entry_index_o;

  table_op_t  op_q[$];
  table_res_t result_due_q[$];

  logic [IdW-1:0] tbl_id [Slots];
  logic           tbl_a  [Slots];
  logic           tbl_b  [Slots];

  int   err_cnt = 0;
  int   xfer_cnt = 0;
  int   total_ops = 0;
  int   send_gap = 0;
  int   stall_left = 0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  bit   hold_off = 1'b0;

  id_slot_table_with_flags_unit #(
    .SLOT_COUNT(Slots)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .slot_id_i       (slot_id_i),
    .object_present_i(object_present_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .flag_value_o    (flag_value_o),
    .matched_o       (matched_o),
    .dropped_o       (dropped_o),
    .entry_index_o   (entry_index_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic table_clear();
    for (int i = 0; i < Slots; i++) begin
      tbl_id[i] = EMPTY_ID;
      tbl_a[i]  = 1'b0;
      tbl_b[i]  = 1'b0;
    end
  endtask

  task automatic table_apply(input table_op_t op, output table_res_t r);
    int hit;
    int free_slot;
    r = '{flag: 1'b0, matched: 1'b0, dropped: 1'b0, idx: '0};
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < Slots; i++) begin
      if (hit < 0 && tbl_id[i] == op.id) hit = i;
      if (free_slot < 0 && tbl_id[i] == EMPTY_ID) free_slot = i;
    end
    case (op.action)
      ACT_CLEAR: table_clear();
      ACT_TOGGLE: begin
        if (op.present && hit >= 0) begin
          tbl_a[hit] = ~tbl_a[hit];
          r.flag     = tbl_a[hit];
          r.matched  = 1'b1;
          r.idx      = hit[OutIdxW-1:0];
        end
      end
      ACT_MARK: begin
        if (hit >= 0) begin
          tbl_b[hit] = 1'b1;
          r.matched  = 1'b1;
          r.idx      = hit[OutIdxW-1:0];
        end else if (free_slot >= 0) begin
          tbl_id[free_slot] = op.id;
          tbl_a[free_slot]  = (op.id == AUTO_A_ID);
          tbl_b[free_slot]  = 1'b1;
          r.idx             = free_slot[OutIdxW-1:0];
        end else begin
          r.dropped = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_op(input logic [ActW-1:0] action, input logic [IdW-1:0] id,
                         input logic present);
    op_q.push_back('{action: action, id: id, present: present});
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  // mostly short, now and then long
  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // driver
  always @(negedge clk_i) begin
    table_op_t nxt;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (send_gap > 0 || op_q.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_valid_i <= 1'b0;
      end else begin
        nxt = op_q.pop_front();
        action_i         <= nxt.action;
        slot_id_i        <= nxt.id;
        object_present_i <= nxt.present;
        in_valid_i       <= 1'b1;
        send_gap = ((xfer_cnt / 150) % 4 == 1) ? 0 : draw_gap();
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_off) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (out_fire && (xfer_cnt / 150) % 4 != 2) stall_left = draw_gap();
    end
  end

  // monitor: results checked first, then the accepted transfer is predicted
  always @(posedge clk_i) begin
    table_op_t  seen;
    table_res_t want;
    table_res_t due;
    if (rst_ni) begin
      out_fire <= out_valid_o && out_ready_i;
      in_fire  <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        if (result_due_q.size() == 0) begin
          report_mismatch("result with none due");
        end else begin
          want = result_due_q.pop_front();
          if (flag_value_o !== want.flag)
            report_mismatch($sformatf("flag_value got %0b want %0b", flag_value_o, want.flag));
          if (matched_o !== want.matched)
            report_mismatch($sformatf("matched got %0b want %0b", matched_o, want.matched));
          if (dropped_o !== want.dropped)
            report_mismatch($sformatf("dropped got %0b want %0b", dropped_o, want.dropped));
          if (entry_index_o !== want.idx)
            report_mismatch($sformatf("entry_index got %0d want %0d", entry_index_o, want.idx));
        end
      end
      if (in_valid_i && in_ready_o) begin
        seen.action  = action_i;
        seen.id      = slot_id_i;
        seen.present = object_present_i;
        table_apply(seen, due);
        result_due_q.push_back(due);
        xfer_cnt++;
      end
    end
  end

  // back-pressure: long receiver hold-off while the sender keeps offering
  initial begin
    wait (xfer_cnt >= 400);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (80) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [IdW-1:0] pool [10];
    int             roll;
    logic [IdW-1:0] rid;

    table_clear();

    // directed
    push_op(ACT_TOGGLE, 32'd5, 1'b1);        // no match on empty table
    push_op(ACT_TOGGLE, 32'd5, 1'b0);        // no object
    push_op(ACT_MARK, AUTO_A_ID, 1'b0);      // claim, flag a set automatically
    push_op(ACT_TOGGLE, AUTO_A_ID, 1'b1);
    push_op(ACT_MARK, 32'h7FFF_FFFF, 1'b1);
    push_op(ACT_MARK, 32'h8000_0000, 1'b0);
    push_op(ACT_MARK, 32'h0000_0000, 1'b1);
    push_op(ACT_MARK, EMPTY_ID, 1'b0);       // matches first empty entry
    push_op(ACT_TOGGLE, EMPTY_ID, 1'b1);
    push_op(ACT_SPARE, 32'h5A5A_A5A5, 1'b1);
    push_op(ACT_MARK, 32'h7FFF_FFFF, 1'b0);  // existing entry
    push_op(ACT_MARK, 32'd10, 1'b0);
    push_op(ACT_MARK, 32'd11, 1'b1);
    push_op(ACT_MARK, 32'd12, 1'b0);
    push_op(ACT_MARK, 32'd13, 1'b0);         // table now full
    push_op(ACT_MARK, 32'd99, 1'b1);         // dropped
    push_op(ACT_MARK, EMPTY_ID, 1'b1);       // full, -1 dropped too
    push_op(ACT_TOGGLE, 32'd13, 1'b1);
    push_op(ACT_TOGGLE, 32'h8000_0000, 1'b1);
    push_op(ACT_CLEAR, 32'hFFFF_FFFF, 1'b1);
    push_op(ACT_TOGGLE, 32'd13, 1'b1);
    push_op(ACT_MARK, 32'd7, 1'b0);
    push_op(ACT_TOGGLE, 32'd7, 1'b1);

    // random: small id pools so entries get hit, filled and overflowed
    foreach (pool[k]) pool[k] = $urandom;
    for (int n = 0; n < RandOps; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        push_op(ACT_CLEAR, $urandom, 1'($urandom_range(0, 1)));
        foreach (pool[k]) begin
          case ($urandom_range(0, 5))
            0:       pool[k] = AUTO_A_ID;
            1:       pool[k] = EMPTY_ID;
            2, 3:    pool[k] = $urandom_range(0, 20);
            default: pool[k] = $urandom;
          endcase
        end
      end else if (roll < 5) begin
        push_op(ACT_SPARE, $urandom, 1'($urandom_range(0, 1)));
      end else begin
        rid = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 9)] : $urandom;
        push_op((roll < 50) ? ACT_TOGGLE : ACT_MARK, rid, $urandom_range(0, 9) != 0);
      end
    end
    total_ops = op_q.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (xfer_cnt == total_ops && result_due_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/istf_pkg.sv
src/istf_ctrl.sv
src/istf_dp.sv
src/id_slot_table_with_flags_unit.sv
tb/tb_id_slot_table_with_flags_unit.sv
